// File: design/sblru_pkg.sv
// Package for the size-budget LRU table: widths, action codes, FSM states.
// No dependencies.
package sblru_pkg;
  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned KeyW    = 64;
  localparam int unsigned WcW     = 22;
  localparam int unsigned SizeW   = 24;
  localparam int unsigned TotW    = 32;
  localparam int unsigned CntW    = $clog2(Entries + 1);
  localparam logic [SizeW-1:0] HeaderBytes = SizeW'(28);
  localparam logic [TotW-1:0]  BudgetReset = TotW'(67108864);

  typedef enum logic [1:0] {
    ActInsert = 2'd0,
    ActTouch  = 2'd1,
    ActRemove = 2'd2,
    ActClear  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StApply,
    StEvict,
    StOut
  } state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [KeyW-1:0]  key;
    logic [WcW-1:0]   word_count;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic [KeyW-1:0]  out_key;
    logic [SizeW-1:0] freed_size;
    logic             hit;
    logic [TotW-1:0]  total_after;
    logic             last;
  } rsp_t;

  // entry size, saturated to 24 bits
  function automatic logic [SizeW-1:0] entry_size(input logic [WcW-1:0] wc);
    logic [WcW+2:0] s;
    s = {wc, 2'b00} + (WcW+3)'(HeaderBytes);
    return (s > (WcW+3)'({SizeW{1'b1}})) ? {SizeW{1'b1}} : s[SizeW-1:0];
  endfunction
endpackage

// File: design/sblru_req_if.sv
// Valid/ready channel carrying one request item.
// Depends on sblru_pkg.
interface sblru_req_if;
  logic           valid;
  logic           ready;
  sblru_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/sblru_rsp_if.sv
// Valid/ready channel carrying one result item.
// Depends on sblru_pkg.
interface sblru_rsp_if;
  logic           valid;
  logic           ready;
  sblru_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/size_budget_lru_table.sv
// Size-budget LRU table: 16 keyed entries kept in recency order under a total
// byte budget.
// Channels: req (action, key, word_count) in, rsp (kind, out_key, freed_size,
// hit, total_after, last) out, both valid/ready, a transfer when both high.
// cfg_we_i/cfg_data_i write the size budget; write only while idle.
// Each request is followed by zero or more eviction reports and then one
// status with last set. Without evictions a scan of all slots finds key,
// free slot and oldest entry, then an apply step sends the status. Each
// eviction adds a further scan and one evict step that sends its report;
// the status follows the last report. The scan unit sets the rate.
// A request is taken only when no earlier result is pending.
// Reset empties the table, clears the total and restores budget 67108864.
// A stalled receiver holds the result register; the evict and status steps wait.
// Depends on sblru_pkg, sblru_req_if, sblru_rsp_if, sblru_scan.
module size_budget_lru_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sblru_pkg::TotW-1:0]    cfg_data_i,
  sblru_req_if.sink                     req,
  sblru_rsp_if.source                   rsp
);
  localparam int unsigned N = sblru_pkg::Entries;
  localparam int unsigned IW = sblru_pkg::IdxW;

  sblru_pkg::state_e state_q, state_d;
  logic [sblru_pkg::TotW-1:0]  budget_q, total_q, total_d;
  logic [N-1:0]                valid_q, valid_d;
  logic [IW-1:0]               rank_q [N];
  logic [IW-1:0]               rank_d [N];
  logic [sblru_pkg::KeyW-1:0]  keys_q [N];
  logic [sblru_pkg::SizeW-1:0] sizes_q [N];
  logic                        kwe, swe;
  logic [IW-1:0]               widx;
  logic [sblru_pkg::SizeW-1:0] wsize;
  sblru_pkg::req_t             req_q;
  sblru_pkg::rsp_t             rsp_q, rsp_d;
  logic                        ovalid_q, ovalid_d;
  logic [sblru_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [sblru_pkg::CntW-1:0]  nev_q, nev_d;
  logic                        evict_mode_q, evict_mode_d;
  logic                        hit_q, hit_d;
  logic                        start;
  logic                        done;
  logic [IW-1:0]               slot, hidx, fidx, oidx;
  logic                        shit, sfree;
  logic [sblru_pkg::SizeW-1:0] nsize;
  logic [IW-1:0]               sel, oldr;
  logic                        occupied;

  sblru_scan u_scan (
    .clk_i, .rst_ni, .start_i(start), .key_i(req_q.key), .valid_i(valid_q),
    .slot_key_i(keys_q[slot]), .slot_rank_i(rank_q[slot]), .slot_o(slot),
    .done_o(done), .hit_o(shit), .hit_idx_o(hidx), .free_o(sfree),
    .free_idx_o(fidx), .old_idx_o(oidx)
  );

  assign req.ready = (state_q == sblru_pkg::StIdle) && !ovalid_q;
  assign rsp.valid = ovalid_q;
  assign rsp.data  = rsp_q;
  assign nsize     = sblru_pkg::entry_size(req_q.word_count);

  always_comb begin
    state_d = state_q; total_d = total_q; valid_d = valid_q; rank_d = rank_q;
    ovalid_d = ovalid_q; rsp_d = rsp_q; cnt_d = cnt_q; nev_d = nev_q;
    evict_mode_d = evict_mode_q; hit_d = hit_q;
    kwe = 1'b0; swe = 1'b0; widx = '0; wsize = nsize; sel = '0; oldr = '0;
    start = 1'b0; occupied = 1'b0;
    if (ovalid_q && rsp.ready) ovalid_d = 1'b0;
    unique case (state_q)
      sblru_pkg::StIdle: begin
        if (req.valid && req.ready) begin
          start = 1'b1; evict_mode_d = 1'b0; nev_d = '0;
          state_d = sblru_pkg::StScan;
        end
      end
      sblru_pkg::StScan: begin
        if (done) state_d = evict_mode_q ? sblru_pkg::StEvict : sblru_pkg::StApply;
      end
      sblru_pkg::StApply: begin
        hit_d = shit;
        rsp_d.kind = 1'b0; rsp_d.out_key = req_q.key; rsp_d.freed_size = '0;
        rsp_d.hit = shit; rsp_d.last = 1'b1;
        state_d = sblru_pkg::StOut;
        unique case (sblru_pkg::action_e'(req_q.action))
          sblru_pkg::ActInsert: begin
            occupied = shit || sfree;
            sel = shit ? hidx : fidx;
            oldr = shit ? rank_q[hidx] : IW'(N - 1);
            if (occupied) begin
              swe = 1'b1; widx = sel; kwe = !shit;
              total_d = total_q - (shit ? 32'(sizes_q[hidx]) : '0) + 32'(nsize);
              for (int i = 0; i < N; i++) begin
                if (valid_q[i] && IW'(i) != sel && (!shit || rank_q[i] < oldr))
                  rank_d[i] = rank_q[i] + 1'b1;
              end
              rank_d[sel] = '0;
              valid_d[sel] = 1'b1;
              if (!shit) cnt_d = cnt_q + 1'b1;
            end
            if ((occupied && ((total_d > budget_q) ||
                              (cnt_d == sblru_pkg::CntW'(N)))) ||
                (!occupied && cnt_q != '0 &&
                 ((total_q > budget_q) || (cnt_q == sblru_pkg::CntW'(N))))) begin
              evict_mode_d = 1'b1; start = 1'b1; state_d = sblru_pkg::StScan;
            end else begin
              rsp_d.total_after = total_d; ovalid_d = 1'b1;
            end
          end
          sblru_pkg::ActTouch: begin
            if (shit) begin
              for (int i = 0; i < N; i++)
                if (valid_q[i] && rank_q[i] < rank_q[hidx]) rank_d[i] = rank_q[i] + 1'b1;
              rank_d[hidx] = '0;
            end
            rsp_d.total_after = total_q; ovalid_d = 1'b1;
          end
          sblru_pkg::ActRemove: begin
            if (shit) begin
              valid_d[hidx] = 1'b0; cnt_d = cnt_q - 1'b1;
              total_d = total_q - 32'(sizes_q[hidx]);
              rsp_d.freed_size = sizes_q[hidx];
              for (int i = 0; i < N; i++)
                if (valid_q[i] && rank_q[i] > rank_q[hidx]) rank_d[i] = rank_q[i] - 1'b1;
            end
            rsp_d.total_after = total_d; ovalid_d = 1'b1;
          end
          sblru_pkg::ActClear: begin
            valid_d = '0; cnt_d = '0; total_d = '0; hit_d = 1'b0;
            for (int i = 0; i < N; i++) rank_d[i] = '0;
            rsp_d.hit = 1'b0; rsp_d.total_after = '0; ovalid_d = 1'b1;
          end
          default: ;
        endcase
      end
      sblru_pkg::StEvict: begin
        if (!ovalid_q || rsp.ready) begin
          valid_d[oidx] = 1'b0; cnt_d = cnt_q - 1'b1; nev_d = nev_q + 1'b1;
          total_d = total_q - 32'(sizes_q[oidx]);
          rsp_d.kind = 1'b1; rsp_d.out_key = keys_q[oidx];
          rsp_d.freed_size = sizes_q[oidx]; rsp_d.hit = 1'b0;
          rsp_d.total_after = total_d; rsp_d.last = 1'b0; ovalid_d = 1'b1;
          for (int i = 0; i < N; i++)
            if (valid_q[i] && rank_q[i] > rank_q[oidx]) rank_d[i] = rank_q[i] - 1'b1;
          if (cnt_d != '0 && nev_d != sblru_pkg::CntW'(N) &&
              ((total_d > budget_q) || (cnt_d == sblru_pkg::CntW'(N)))) begin
            start = 1'b1; state_d = sblru_pkg::StScan;
          end else begin
            state_d = sblru_pkg::StOut;
          end
        end
      end
      sblru_pkg::StOut: begin
        // final status once any eviction report has gone
        if (!evict_mode_q) begin
          if (!ovalid_q || rsp.ready) state_d = sblru_pkg::StIdle;
        end else if (!ovalid_q || rsp.ready) begin
          rsp_d.kind = 1'b0; rsp_d.out_key = req_q.key; rsp_d.freed_size = '0;
          rsp_d.hit = hit_q; rsp_d.total_after = total_q; rsp_d.last = 1'b1;
          ovalid_d = 1'b1; evict_mode_d = 1'b0;
        end
      end
      default: state_d = sblru_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sblru_pkg::StIdle; budget_q <= sblru_pkg::BudgetReset;
      total_q <= '0; valid_q <= '0; ovalid_q <= 1'b0; cnt_q <= '0; nev_q <= '0;
      evict_mode_q <= 1'b0; hit_q <= 1'b0;
      for (int i = 0; i < N; i++) rank_q[i] <= '0;
    end else begin
      state_q <= state_d; total_q <= total_d; valid_q <= valid_d;
      ovalid_q <= ovalid_d; cnt_q <= cnt_d; nev_q <= nev_d;
      evict_mode_q <= evict_mode_d; hit_q <= hit_d; rank_q <= rank_d;
      if (cfg_we_i) budget_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (req.valid && req.ready) req_q <= req.data;
    if (kwe) keys_q[widx] <= req_q.key;
    if (swe) sizes_q[widx] <= wsize;
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == sblru_pkg::CntW'($countones(valid_q))) else $error("count mismatch");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !ovalid_q) else $error("ready with result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !rsp.ready |=> ovalid_q) else $error("result dropped");
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sblru_pkg::StEvict |-> !evict_mode_q || nev_q < sblru_pkg::CntW'(N))
    else $error("too many evictions");
endmodule

// File: design/sblru_scan.sv
// Shared scan unit: steps one slot per cycle, matching the key, finding a free
// slot and the least-recent slot. Depends on sblru_pkg.
module sblru_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sblru_pkg::KeyW-1:0]  key_i,
  input  logic [sblru_pkg::Entries-1:0] valid_i,
  input  logic [sblru_pkg::KeyW-1:0]  slot_key_i,
  input  logic [sblru_pkg::IdxW-1:0]  slot_rank_i,
  output logic [sblru_pkg::IdxW-1:0]  slot_o,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [sblru_pkg::IdxW-1:0]  hit_idx_o,
  output logic                        free_o,
  output logic [sblru_pkg::IdxW-1:0]  free_idx_o,
  output logic [sblru_pkg::IdxW-1:0]  old_idx_o
);
  logic                       busy_q, busy_d;
  logic [sblru_pkg::IdxW-1:0] ptr_q, ptr_d;
  logic                       hit_q, hit_d, free_q, free_d, oldv_q, oldv_d;
  logic [sblru_pkg::IdxW-1:0] hidx_q, hidx_d, fidx_q, fidx_d, oidx_q, oidx_d;
  logic [sblru_pkg::IdxW-1:0] orank_q, orank_d;
  logic                       v;

  assign slot_o = ptr_q;
  assign v      = valid_i[ptr_q];

  always_comb begin
    busy_d = busy_q; ptr_d = ptr_q;
    hit_d = hit_q; hidx_d = hidx_q; free_d = free_q; fidx_d = fidx_q;
    oldv_d = oldv_q; oidx_d = oidx_q; orank_d = orank_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1; ptr_d = '0;
      hit_d = 1'b0; free_d = 1'b0; oldv_d = 1'b0;
    end else if (busy_q) begin
      if (v && slot_key_i == key_i && !hit_q) begin
        hit_d = 1'b1; hidx_d = ptr_q;
      end
      if (!v && !free_q) begin
        free_d = 1'b1; fidx_d = ptr_q;
      end
      if (v && (!oldv_q || slot_rank_i > orank_q)) begin
        oldv_d = 1'b1; oidx_d = ptr_q; orank_d = slot_rank_i;
      end
      if (ptr_q == sblru_pkg::IdxW'(sblru_pkg::Entries - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        ptr_d = ptr_q + 1'b1;
      end
    end
  end

  // results valid the cycle after done_o
  assign hit_o = hit_q; assign hit_idx_o = hidx_q;
  assign free_o = free_q; assign free_idx_o = fidx_q;
  assign old_idx_o = oidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; ptr_q <= '0;
      hit_q <= 1'b0; free_q <= 1'b0; oldv_q <= 1'b0;
    end else begin
      busy_q <= busy_d; ptr_q <= ptr_d;
      hit_q <= hit_d; free_q <= free_d; oldv_q <= oldv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hidx_q <= hidx_d; fidx_q <= fidx_d; oidx_q <= oidx_d; orank_q <= orank_d;
  end

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q) else $error("scan done while idle");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("scan restarted while busy");
  a_done_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("scan still busy after done");
endmodule
